// ===== rtl/mpspk_pkg.sv =====
// shared types and constants for the program stream packetizer
package mpspk_pkg;

    localparam logic [7:0] ID_PACK   = 8'hBA;
    localparam logic [7:0] ID_SYSHDR = 8'hBB;
    localparam logic [7:0] ID_END    = 8'hB9;
    localparam logic [7:0] ID_LOW    = 8'hBD;
    localparam logic [7:0] ID_HIGH   = 8'hFE;

    localparam logic [23:0] START_PREFIX = 24'h000001;

    localparam int REM_W = 17;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] packet_id;
        logic       first_mark;
        logic       last_mark;
        logic       mpeg2_seen;
    } result_t;

endpackage

// ===== rtl/mpspk_parser.sv =====
// look-ahead window, start code parser and packet state
module mpspk_parser
    import mpspk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output logic       push,
    output result_t    result
);

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_PACKET = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;
    localparam logic [1:0] PH_CHUNK  = 2'd3;

    logic [31:0]      window_reg, window_next;
    logic [2:0]       fill_reg, fill_next;
    logic [1:0]       phase_reg, phase_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [2:0]       pos_reg, pos_next;
    logic [7:0]       id_reg, id_next;
    logic             resync_reg, resync_next;
    logic             mpeg2_reg, mpeg2_next;
    logic             mode_reg;

    logic [7:0] w0;
    logic [7:0] w3;
    logic       code_here;
    logic       unknown_id;
    logic       last;
    logic       hit;

    assign w0 = window_reg[31:24];
    assign w3 = window_reg[7:0];
    assign code_here = (window_reg[31:8] == START_PREFIX);
    assign unknown_id = (w3 != ID_PACK) && (w3 != ID_SYSHDR) && (w3 != ID_END)
                        && mpeg2_reg && ((w3 < ID_LOW) || (w3 > ID_HIGH));

    always_comb
    begin
        window_next = {window_reg[23:0], in_byte};
        fill_next   = fill_reg;
        phase_next  = phase_reg;
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        id_next     = id_reg;
        resync_next = resync_reg;
        mpeg2_next  = mpeg2_reg;
        hit         = 1'b0;
        last        = 1'b0;
        if (fill_reg != 3'd4)
        begin
            fill_next = fill_reg + 3'd1;
        end
        else
        begin
            if ((phase_reg == PH_HUNT) && code_here)
            begin
                if (mode_reg)
                begin
                    id_next    = w3;
                    pos_next   = 3'd0;
                    phase_next = PH_CHUNK;
                end
                else if ((resync_reg && (w3 != ID_PACK)) || unknown_id)
                begin
                    phase_next = PH_SKIP;
                    rem_next   = REM_W'(4);
                end
                else
                begin
                    id_next    = w3;
                    pos_next   = 3'd0;
                    phase_next = PH_PACKET;
                    if (w3 == ID_PACK)
                    begin
                        resync_next = 1'b0;
                        mpeg2_next  = (in_byte[7:6] == 2'b01);
                        rem_next    = mpeg2_next ? REM_W'(13) : REM_W'(11);
                    end
                    else if (w3 == ID_END)
                    begin
                        rem_next = REM_W'(3);
                    end
                    else
                    begin
                        rem_next = REM_W'(5);
                    end
                end
            end
            case (phase_next)
                PH_PACKET:
                begin
                    if ((pos_next == 3'd1) && (id_next != ID_PACK) && (id_next != ID_END))
                    begin
                        rem_next = REM_W'({w3, in_byte}) + REM_W'(4);
                    end
                    last = (rem_next == '0);
                    hit  = 1'b1;
                    if (last)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        rem_next = rem_next - REM_W'(1);
                    end
                end
                PH_CHUNK:
                begin
                    last = (pos_next >= 3'd3) && (window_reg[23:0] == START_PREFIX);
                    hit  = 1'b1;
                    if (last)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_SKIP:
                begin
                    rem_next = rem_next - REM_W'(1);
                    if (rem_next == '0)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                end
            endcase
            if (hit && (pos_next != 3'd7))
            begin
                pos_next = pos_next + 3'd1;
            end
        end
    end

    // result uses the id and flag as updated by this word
    always_comb
    begin
        result.out_byte   = w0;
        result.packet_id  = id_next;
        result.first_mark = (phase_next != PH_SKIP) && hit && (pos_next == 3'd1)
                            && (pos_reg != 3'd0 || phase_reg == PH_HUNT || fill_reg != 3'd4);
        result.last_mark  = last;
        result.mpeg2_seen = mpeg2_next;
    end

    assign push = accept && hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
            phase_reg  <= PH_HUNT;
            rem_reg    <= '0;
            pos_reg    <= '0;
            id_reg     <= '0;
            resync_reg <= 1'b1;
            mpeg2_reg  <= 1'b0;
            mode_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                window_reg <= window_next;
                fill_reg   <= fill_next;
                phase_reg  <= phase_next;
                rem_reg    <= rem_next;
                pos_reg    <= pos_next;
                id_reg     <= id_next;
                resync_reg <= resync_next;
                mpeg2_reg  <= mpeg2_next;
            end
        end
    end

    a_no_word_while_filling: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != 3'd4) |-> !push)
        else $error("word emitted before window full");

    a_skip_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> ((rem_reg >= REM_W'(1)) && (rem_reg <= REM_W'(4))))
        else $error("skip count out of range");

    a_packet_after_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PACKET) |-> !resync_reg)
        else $error("system packet before pack header");

endmodule

// ===== rtl/mpspk_out_buf.sv =====
// two-word result buffer between parser and output channel
module mpspk_out_buf
    import mpspk_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t    slot_reg [2];
    logic       head_reg, head_next;
    logic [1:0] count_reg, count_next;
    logic       pop;
    logic       tail;

    assign out_valid = (count_reg != 2'd0);
    assign space     = (count_reg != 2'd2);
    assign pop       = out_valid && out_ready;
    assign tail      = head_reg ^ count_reg[0];
    assign out_data  = slot_reg[head_reg];

    always_comb
    begin
        head_next  = pop ? ~head_reg : head_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("buffer count overflow");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2))
        else $error("push into full buffer");

endmodule

// ===== rtl/mpeg_ps_packetizer.sv =====
// program stream packetizer top level
// Takes one stream byte per cycle while in_ready is high and gives each packet
// byte four words after the byte entered, tagged with its start code id and
// first and last marks. Bytes outside packets give no output word. The parser
// holds a four-byte window and updates its packet state once per byte; results
// go into a two-word output buffer, so in_ready falls only when that buffer is
// full, and a word accepted with the output free appears on the next cycle.
module mpeg_ps_packetizer
    import mpspk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [7:0] packet_id,
    output logic       first_mark,
    output logic       last_mark,
    output logic       mpeg2_seen
);

    logic    accept;
    logic    push;
    logic    space;
    result_t result;
    result_t out_data;

    assign in_ready = space;
    assign accept   = in_valid && space;

    mpspk_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .in_byte     (in_byte),
        .push        (push),
        .result      (result)
    );

    mpspk_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign out_byte   = out_data.out_byte;
    assign packet_id  = out_data.packet_id;
    assign first_mark = out_data.first_mark;
    assign last_mark  = out_data.last_mark;
    assign mpeg2_seen = out_data.mpeg2_seen;

endmodule
